@@ hw/rtl/u8250_pkg.sv @@
// Package for the 8250 UART register model: request and response types,
// command, access size and exception codes, and register offsets.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package u8250_pkg;

   // Command codes carried by a request.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_POLL  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // Bus access sizes.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_BAD  = 2'd3;

   // Exception codes reported in a response.
   localparam logic [1:0] EXC_NONE          = 2'd0;
   localparam logic [1:0] EXC_LOAD_MISALIGN = 2'd1;
   localparam logic [1:0] EXC_STORE_MISALIGN = 2'd2;
   localparam logic [1:0] EXC_ILLEGAL       = 2'd3;

   // Register offsets.
   localparam logic [2:0] REG_RBR = 3'd0;
   localparam logic [2:0] REG_IER = 3'd1;
   localparam logic [2:0] REG_IIR = 3'd2;
   localparam logic [2:0] REG_LCR = 3'd3;
   localparam logic [2:0] REG_MCR = 3'd4;
   localparam logic [2:0] REG_LSR = 3'd5;
   localparam logic [2:0] REG_MSR = 3'd6;
   localparam logic [2:0] REG_NONE = 3'd7;

   // Fixed register contents and bit positions.
   localparam logic [7:0] LSR_BASE  = 8'h60;
   localparam logic [7:0] MSR_VALUE = 8'hb0;
   localparam int unsigned DLAB_BIT = 7;
   localparam logic [2:0] INT_THRE  = 3'd1;

   // One request item.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  reg_addr;
      logic [1:0]  access_size;
      logic        sign_extend;
      logic [7:0]  write_data;
      logic [7:0]  rx_char;
      logic [31:0] fault_address;
   } req_type;

   // One response item.
   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  exception_code;
      logic [31:0] exception_value;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        irq_pending;
      logic [2:0]  irq_id;
   } rsp_type;

endpackage

@@ hw/rtl/u8250_core.sv @@
// Register file and access decode of the 8250 UART model.
// Holds all UART state and computes one response per request.
// Depends on u8250_pkg.
`timescale 1ns / 1ps

module u8250_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  u8250_pkg::req_type req,
   output u8250_pkg::rsp_type rsp
);

   logic       rx_ready_ff, rx_ready_in;
   logic [7:0] rx_holding_ff, rx_holding_in;
   logic [7:0] pending_ff, pending_in;
   logic [2:0] current_id_ff, current_id_in;
   logic [7:0] int_enable_ff, int_enable_in;
   logic [7:0] line_control_ff, line_control_in;
   logic [7:0] modem_control_ff, modem_control_in;
   logic [7:0] divisor_low_ff, divisor_low_in;
   logic [7:0] divisor_high_ff, divisor_high_in;

   logic       dlab;
   logic [7:0] rbyte;
   logic [7:0] pend;

   assign dlab = line_control_ff[u8250_pkg::DLAB_BIT];

   // Register access decode, receiver poll and response fields.
   always_comb begin
      rx_ready_in      = rx_ready_ff;
      rx_holding_in    = rx_holding_ff;
      int_enable_in    = int_enable_ff;
      line_control_in  = line_control_ff;
      modem_control_in = modem_control_ff;
      divisor_low_in   = divisor_low_ff;
      divisor_high_in  = divisor_high_ff;
      pend             = pending_ff;
      rbyte            = 8'h00;
      rsp              = '0;

      case (req.cmd)
         u8250_pkg::CMD_READ: begin
            if (req.access_size == u8250_pkg::SIZE_BYTE) begin
               case (req.reg_addr)
                  u8250_pkg::REG_RBR: begin
                     if (dlab) begin
                        rbyte = divisor_low_ff;
                     end else begin
                        // Poll first; a held character wins over the new one.
                        rbyte = rx_ready_ff ? rx_holding_ff : req.rx_char;
                        if (!rx_ready_ff) begin
                           rx_holding_in = req.rx_char;
                        end
                        rx_ready_in = 1'b0;
                     end
                  end
                  u8250_pkg::REG_IER: rbyte = dlab ? divisor_high_ff : int_enable_ff;
                  u8250_pkg::REG_IIR: begin
                     rbyte = {4'h0, current_id_ff, (pending_ff == 8'h00)};
                     if (current_id_ff == u8250_pkg::INT_THRE) begin
                        pend[u8250_pkg::INT_THRE] = 1'b0;
                     end
                  end
                  u8250_pkg::REG_LCR: rbyte = line_control_ff;
                  u8250_pkg::REG_MCR: rbyte = modem_control_ff;
                  u8250_pkg::REG_LSR: rbyte = u8250_pkg::LSR_BASE | {7'h00, rx_ready_ff};
                  u8250_pkg::REG_MSR: rbyte = u8250_pkg::MSR_VALUE;
                  default:            rbyte = 8'h00;
               endcase
               rsp.read_data = {{24{req.sign_extend & rbyte[7]}}, rbyte};
            end else if (req.access_size inside {u8250_pkg::SIZE_HALF,
                                                 u8250_pkg::SIZE_WORD}) begin
               rsp.exception_code  = u8250_pkg::EXC_LOAD_MISALIGN;
               rsp.exception_value = req.fault_address;
            end else begin
               rsp.exception_code = u8250_pkg::EXC_ILLEGAL;
            end
         end
         u8250_pkg::CMD_WRITE: begin
            if (req.access_size == u8250_pkg::SIZE_BYTE) begin
               case (req.reg_addr)
                  u8250_pkg::REG_RBR: begin
                     if (dlab) begin
                        divisor_low_in = req.write_data;
                     end else begin
                        // A transmit write raises the THRE interrupt.
                        pend[u8250_pkg::INT_THRE] = 1'b1;
                        rsp.tx_valid = 1'b1;
                        rsp.tx_byte  = req.write_data;
                     end
                  end
                  u8250_pkg::REG_IER: begin
                     if (dlab) begin
                        divisor_high_in = req.write_data;
                     end else begin
                        int_enable_in = req.write_data;
                     end
                  end
                  u8250_pkg::REG_LCR: line_control_in  = req.write_data;
                  u8250_pkg::REG_MCR: modem_control_in = req.write_data;
                  default: ;
               endcase
            end else if (req.access_size inside {u8250_pkg::SIZE_HALF,
                                                 u8250_pkg::SIZE_WORD}) begin
               rsp.exception_code  = u8250_pkg::EXC_STORE_MISALIGN;
               rsp.exception_value = req.fault_address;
            end else begin
               rsp.exception_code = u8250_pkg::EXC_ILLEGAL;
            end
         end
         u8250_pkg::CMD_POLL: begin
            if (!rx_ready_ff) begin
               rx_holding_in = req.rx_char;
               rx_ready_in   = (req.rx_char != 8'h00);
            end
         end
         default: ;
      endcase

      // Interrupt recompute: receive bit follows rx_ready, then the enable mask.
      pend[0] = rx_ready_in;
      pending_in = pend & int_enable_in;

      // Highest pending bit becomes the identity; it holds when nothing pends.
      current_id_in = current_id_ff;
      for (int b = 0; b < 8; b++) begin
         if (pending_in[b]) begin
            current_id_in = 3'(b);
         end
      end
      rsp.irq_pending = (pending_in != 8'h00);
      rsp.irq_id      = current_id_in;
   end

   // State registers advance once per request that moves to the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ready_ff      <= 1'b0;
         rx_holding_ff    <= 8'h00;
         pending_ff       <= 8'h00;
         current_id_ff    <= 3'd0;
         int_enable_ff    <= 8'h00;
         line_control_ff  <= 8'h00;
         modem_control_ff <= 8'h00;
         divisor_low_ff   <= 8'h00;
         divisor_high_ff  <= 8'h00;
      end else if (step) begin
         rx_ready_ff      <= rx_ready_in;
         rx_holding_ff    <= rx_holding_in;
         pending_ff       <= pending_in;
         current_id_ff    <= current_id_in;
         int_enable_ff    <= int_enable_in;
         line_control_ff  <= line_control_in;
         modem_control_ff <= modem_control_in;
         divisor_low_ff   <= divisor_low_in;
         divisor_high_ff  <= divisor_high_in;
      end
   end

endmodule

@@ hw/rtl/uart_8250_register_model_top.sv @@
// Top level of the 8250 UART register model: request register, register
// file core and response register. Depends on u8250_pkg and u8250_core.
`timescale 1ns / 1ps

// Usage:
// A request (bus read, bus write or receiver poll) enters on req_valid /
// req_ready with its fields in req_data. Each request yields exactly one
// response on rsp_valid / rsp_ready with its fields in rsp_data, in order.
// A request accepted at a clock edge is latched in the request register,
// decoded against the register file while it is held there, and its
// response is loaded into the response register when it moves on. The
// UART state updates in the same edge that loads the response register,
// so one request per cycle is sustained while rsp_ready stays high.
// When the receiver holds rsp_ready low, the response register keeps its
// contents and the request register holds the next request; req_ready
// stays high while the request register is empty, so a single request is
// still taken during a stall. Back pressure then reaches req_ready.
// Reset (synchronous, active high) clears all UART registers to zero and
// empties both the request and the response register.

module uart_8250_register_model_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u8250_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u8250_pkg::rsp_type rsp_data
);

   logic               in_valid_ff;
   u8250_pkg::req_type in_req_ff;
   logic               out_valid_ff;
   u8250_pkg::rsp_type out_rsp_ff;
   u8250_pkg::rsp_type core_rsp;
   logic               advance;

   // A held request moves on when the response register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   u8250_core core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_req_ff <= req_data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

@@ hw/rtl/u8250_checker.sv @@
// Port-level checker for the 8250 UART register model and its bind.
// Depends on u8250_pkg and on the top level's port names.
`timescale 1ns / 1ps

module u8250_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input u8250_pkg::rsp_type rsp_data
);

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A transmit byte only comes from a clean write, which reads nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_valid |->
         rsp_data.exception_code == u8250_pkg::EXC_NONE && rsp_data.read_data == 32'h0)
      else $error("transmit byte on a faulting or reading request");

   // A faulting request has no register effect visible in the response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exception_code != u8250_pkg::EXC_NONE |->
         !rsp_data.tx_valid && rsp_data.read_data == 32'h0 && rsp_data.tx_byte == 8'h0)
      else $error("faulting request shows data");

   // Only misaligned accesses report a fault address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exception_value != 32'h0 |->
         rsp_data.exception_code == u8250_pkg::EXC_LOAD_MISALIGN ||
         rsp_data.exception_code == u8250_pkg::EXC_STORE_MISALIGN)
      else $error("fault address without misaligned exception");

   // Right after reset the response register is empty and a request can be taken.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind uart_8250_register_model_top u8250_checker checker_inst (.*);

@@ test/u8250_checker.sv @@
// Response checker for the 8250 UART register model: predicts each response
// from the accepted requests and compares it field by field.
// Depends on u8250_pkg for the request and response types and codes.
`timescale 1ns / 1ps

module u8250_resp_checker
   import u8250_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned fail_count,
   output int unsigned in_flight
);

   // Predicted UART register state.
   logic       rx_rdy;
   logic [7:0] rx_hold;
   logic [7:0] int_bits;
   logic [2:0] int_id;
   logic [7:0] ier;
   logic [7:0] lcr;
   logic [7:0] mcr;
   logic [7:0] dll;
   logic [7:0] dlm;

   rsp_type     due_rsps[$];
   int unsigned errors = 0;

   assign fail_count = errors;
   assign in_flight  = due_rsps.size();

   // Print one mismatch line and count it.
   task automatic flag_error(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h",
               $time, what, got, want);
      errors++;
   endtask

   // The receiver latches a character only while nothing is waiting.
   function automatic void sample_rx(input logic [7:0] ch);
      if (!rx_rdy) begin
         rx_hold = ch;
         rx_rdy  = (ch != 8'd0);
      end
   endfunction

   // Apply one request to the predicted registers and return its response.
   function automatic rsp_type step_uart(input req_type r);
      rsp_type    o;
      logic [7:0] b;
      logic       dlab;
      o    = '0;
      b    = 8'd0;
      dlab = lcr[DLAB_BIT];
      case (r.cmd)
         CMD_READ: begin
            if (r.access_size == SIZE_BYTE) begin
               case (r.reg_addr)
                  REG_RBR: begin
                     if (dlab) begin
                        b = dll;
                     end else begin
                        sample_rx(r.rx_char);
                        if (rx_rdy) begin
                           rx_rdy = 1'b0;
                           b      = rx_hold;
                        end
                     end
                  end
                  REG_IER: b = dlab ? dlm : ier;
                  REG_IIR: begin
                     // Identity uses the state before the read; a THRE
                     // identity is acknowledged by reading it.
                     b = {4'd0, int_id, (int_bits == 8'd0)};
                     if (int_id == INT_THRE) int_bits[INT_THRE] = 1'b0;
                  end
                  REG_LCR: b = lcr;
                  REG_MCR: b = mcr;
                  REG_LSR: b = LSR_BASE | {7'd0, rx_rdy};
                  REG_MSR: b = MSR_VALUE;
                  default: b = 8'd0;
               endcase
               o.read_data = {{24{r.sign_extend & b[7]}}, b};
            end else if (r.access_size == SIZE_BAD) begin
               o.exception_code = EXC_ILLEGAL;
            end else begin
               o.exception_code  = EXC_LOAD_MISALIGN;
               o.exception_value = r.fault_address;
            end
         end
         CMD_WRITE: begin
            if (r.access_size == SIZE_BYTE) begin
               case (r.reg_addr)
                  REG_RBR: begin
                     if (dlab) begin
                        dll = r.write_data;
                     end else begin
                        int_bits[INT_THRE] = 1'b1;
                        o.tx_valid = 1'b1;
                        o.tx_byte  = r.write_data;
                     end
                  end
                  REG_IER: begin
                     if (dlab) dlm = r.write_data;
                     else ier = r.write_data;
                  end
                  REG_LCR: lcr = r.write_data;
                  REG_MCR: mcr = r.write_data;
                  default: ;
               endcase
            end else if (r.access_size == SIZE_BAD) begin
               o.exception_code = EXC_ILLEGAL;
            end else begin
               o.exception_code  = EXC_STORE_MISALIGN;
               o.exception_value = r.fault_address;
            end
         end
         CMD_POLL: sample_rx(r.rx_char);
         default: ;
      endcase

      // Pending interrupts: bit 0 tracks the receiver, all masked by IER.
      // The identity is kept stale when nothing is pending.
      int_bits[0] = rx_rdy;
      int_bits    = int_bits & ier;
      for (int i = 0; i < 8; i++) begin
         if (int_bits[i]) int_id = i[2:0];
      end
      o.irq_pending = (int_bits != 8'd0);
      o.irq_id      = int_id;
      return o;
   endfunction

   // Check responses first so a response can never match a request taken
   // at the same edge, then predict the newly accepted request.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rx_rdy   = 1'b0;
         rx_hold  = 8'd0;
         int_bits = 8'd0;
         int_id   = 3'd0;
         ier      = 8'd0;
         lcr      = 8'd0;
         mcr      = 8'd0;
         dll      = 8'd0;
         dlm      = 8'd0;
         due_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsps.size() == 0) begin
               flag_error("response with none outstanding, read_data",
                          rsp_data.read_data, 32'd0);
            end else begin
               want = due_rsps.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  flag_error("read_data", rsp_data.read_data, want.read_data);
               if (rsp_data.exception_code !== want.exception_code)
                  flag_error("exception_code", 32'(rsp_data.exception_code),
                             32'(want.exception_code));
               if (rsp_data.exception_value !== want.exception_value)
                  flag_error("exception_value", rsp_data.exception_value,
                             want.exception_value);
               if (rsp_data.tx_valid !== want.tx_valid)
                  flag_error("tx_valid", 32'(rsp_data.tx_valid), 32'(want.tx_valid));
               if (rsp_data.tx_byte !== want.tx_byte)
                  flag_error("tx_byte", 32'(rsp_data.tx_byte), 32'(want.tx_byte));
               if (rsp_data.irq_pending !== want.irq_pending)
                  flag_error("irq_pending", 32'(rsp_data.irq_pending),
                             32'(want.irq_pending));
               if (rsp_data.irq_id !== want.irq_id)
                  flag_error("irq_id", 32'(rsp_data.irq_id), 32'(want.irq_id));
            end
         end
         if (req_valid && req_ready) begin
            due_rsps.push_back(step_uart(req_data));
         end
      end
   end

endmodule

@@ test/tb_uart_8250_register_model_top.sv @@
// Testbench top for the 8250 UART register model: clock, reset, request
// stimulus, response back pressure and the verdict.
// Depends on u8250_pkg, uart_8250_register_model_top and u8250_resp_checker.
`timescale 1ns / 1ps

module tb_uart_8250_register_model_top;
   import u8250_pkg::*;

   localparam int unsigned CLK_PERIOD   = 8;
   localparam int unsigned RANDOM_COUNT = 1350;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 300000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned in_flight;
   int unsigned cycle_count = 0;

   // Shared controls: no idling on either side, a long receiver hold-off,
   // and the final drain with the receiver always ready.
   bit quiet    = 1'b0;
   bit hold_off = 1'b0;
   bit draining = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   uart_8250_register_model_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   u8250_resp_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .in_flight  (in_flight)
   );

   // Idle gap length: mostly none or short, sometimes long.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input logic [2:0] addr,
                                        input logic [1:0] size, input logic sext,
                                        input logic [7:0] wdata, input logic [7:0] ch,
                                        input logic [31:0] faddr);
      req_type r;
      r.cmd           = cmd;
      r.reg_addr      = addr;
      r.access_size   = size;
      r.sign_extend   = sext;
      r.write_data    = wdata;
      r.rx_char       = ch;
      r.fault_address = faddr;
      return r;
   endfunction

   // Mostly byte register accesses and receiver polls with random content;
   // the rest are misaligned, illegal and empty commands.
   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) r.cmd = CMD_READ;
      else if (pick < 75) r.cmd = CMD_WRITE;
      else if (pick < 92) r.cmd = CMD_POLL;
      else r.cmd = CMD_NONE;
      r.reg_addr = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 85) r.access_size = SIZE_BYTE;
      else if (pick < 90) r.access_size = SIZE_HALF;
      else if (pick < 95) r.access_size = SIZE_WORD;
      else r.access_size = SIZE_BAD;
      r.sign_extend = 1'($urandom_range(0, 1));
      r.write_data  = 8'($urandom);
      // Keep the divisor latch open only part of the time.
      if (r.cmd == CMD_WRITE && r.reg_addr == REG_LCR)
         r.write_data[DLAB_BIT] = ($urandom_range(0, 3) == 0);
      r.rx_char       = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom);
      r.fault_address = $urandom;
      return r;
   endfunction

   // Offer one request after an optional gap and wait until it is taken.
   task automatic send_req(input req_type r);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering until every outstanding response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (in_flight == 0);
      @(posedge clock);
   endtask

   // Cycle limit for a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("uart_8250_register_model_top test failed");
         $finish;
      end
   end

   // Response side: random stalls, stall-free stretches, one long hold-off
   // on request, and always ready while draining at the end.
   initial begin
      int unsigned stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else if (draining || quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            stall = idle_cycles();
            if (stall == 0) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
               @(posedge clock);
            end
         end
      end
   end

   // Request side: reset, directed cases, random requests, then verdict.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of every register but LCR, sign extension of a fixed value.
      send_req(make_req(CMD_READ,  REG_RBR, SIZE_BYTE, 1'b1, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_IER, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_IIR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_MCR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_LSR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_MSR, SIZE_BYTE, 1'b1, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_NONE, SIZE_BYTE, 1'b1, 8'h00, 8'hff, 32'h0));
      // Divisor latch behind DLAB: both divisor bytes written and read back.
      send_req(make_req(CMD_WRITE, REG_LCR, SIZE_BYTE, 1'b0, 8'h80, 8'h00, 32'h0));
      send_req(make_req(CMD_WRITE, REG_RBR, SIZE_BYTE, 1'b0, 8'hff, 8'h00, 32'h0));
      send_req(make_req(CMD_WRITE, REG_IER, SIZE_BYTE, 1'b0, 8'h01, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_RBR, SIZE_BYTE, 1'b1, 8'h00, 8'h41, 32'h0));
      send_req(make_req(CMD_READ,  REG_IER, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      // Transmit raises THRE, an IIR read acknowledges it.
      send_req(make_req(CMD_WRITE, REG_LCR, SIZE_BYTE, 1'b0, 8'h03, 8'h00, 32'h0));
      send_req(make_req(CMD_WRITE, REG_IER, SIZE_BYTE, 1'b0, 8'hff, 8'h00, 32'h0));
      send_req(make_req(CMD_WRITE, REG_RBR, SIZE_BYTE, 1'b0, 8'ha5, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_IIR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      // Empty poll, a character arriving, then held while another is offered.
      send_req(make_req(CMD_POLL,  REG_RBR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_POLL,  REG_RBR, SIZE_BYTE, 1'b0, 8'h00, 8'h80, 32'h0));
      send_req(make_req(CMD_READ,  REG_LSR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_RBR, SIZE_BYTE, 1'b1, 8'h00, 8'h55, 32'h0));
      // Misaligned and illegal accesses, the empty command, an ignored MSR write.
      send_req(make_req(CMD_READ,  REG_LCR, SIZE_HALF, 1'b1, 8'h00, 8'h00,
                        32'hffff_ffff));
      send_req(make_req(CMD_WRITE, REG_LCR, SIZE_WORD, 1'b0, 8'h80, 8'h00,
                        32'h8000_0001));
      send_req(make_req(CMD_READ,  REG_RBR, SIZE_BAD, 1'b0, 8'h00, 8'h33, 32'h1234_5678));
      send_req(make_req(CMD_WRITE, REG_RBR, SIZE_BAD, 1'b0, 8'hff, 8'h00, 32'h0));
      send_req(make_req(CMD_NONE,  REG_NONE, SIZE_BAD, 1'b1, 8'hff, 8'hff,
                        32'hffff_ffff));
      send_req(make_req(CMD_WRITE, REG_MSR, SIZE_BYTE, 1'b0, 8'hff, 8'h00, 32'h0));
      send_req(make_req(CMD_WRITE, REG_MCR, SIZE_BYTE, 1'b0, 8'hff, 8'h00, 32'h0));
      send_req(make_req(CMD_READ,  REG_MCR, SIZE_BYTE, 1'b0, 8'h00, 8'h00, 32'h0));

      // Random phase with stall-free stretches, two long receiver hold-offs
      // and one pause until everything has drained.
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
         if (i == 300 || i == 900) hold_off = 1'b1;
         if (i == 600) wait_drained();
         send_req(random_req());
      end
      req_valid <= 1'b0;

      draining = 1'b1;
      wait (in_flight == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && in_flight == 0) begin
         $display("uart_8250_register_model_top test passed");
      end else begin
         $display("uart_8250_register_model_top test failed");
      end
      $finish;
   end

endmodule
